FILE: rtl/rfsb_pkg.sv
// ----------------------------------------------------------------------------
// rfsb_pkg: shared types and constants of the fill and scroll blitter
// Commands, register indexes, status codes, controller states and the
// palette write request.
// ----------------------------------------------------------------------------
package rfsb_pkg;

  localparam int MAX_WIDTH_D  = 1024;
  localparam int MAX_HEIGHT_D = 512;
  localparam int PEN_COUNT_D  = 16;

  localparam logic [23:0] RGB_WHITE = 24'hFFFFFF;
  localparam logic [23:0] RGB_BLACK = 24'h000000;

  typedef enum logic [1:0] {
    CMD_FILL    = 2'd0,
    CMD_SCROLL  = 2'd1,
    CMD_SET_PEN = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_WIDTH      = 2'd0,
    CFG_HEIGHT     = 2'd1,
    CFG_FG_PEN     = 2'd2,
    CFG_COMPLEMENT = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_READ  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    WD_COLOR  = 2'd0,
    WD_SOURCE = 2'd1,
    WD_INVERT = 2'd2
  } wsel_t;

  typedef struct packed {
    logic        we;
    logic [7:0]  idx;
    logic [23:0] data;
  } pen_wr_t;

endpackage

FILE: rtl/rfsb_frame_mem.sv
// ----------------------------------------------------------------------------
// rfsb_frame_mem: frame store
// Simple dual-port synchronous memory, one write and one registered read
// per cycle.
// ----------------------------------------------------------------------------
module rfsb_frame_mem #(
  parameter int AW = 19
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);

  logic [23:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rfsb_palette.sv
// ----------------------------------------------------------------------------
// rfsb_palette: pen palette
// Holds the pen colours and looks up the foreground colour.
// ----------------------------------------------------------------------------
module rfsb_palette #(
  parameter int PEN_COUNT = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rfsb_pkg::pen_wr_t pen_wr,
  input  logic [7:0]       fg_pen,
  output logic [23:0]      fg_color
);
  import rfsb_pkg::*;

  localparam int PW = (PEN_COUNT > 1) ? $clog2(PEN_COUNT) : 1;

  logic [23:0] pal_r [PEN_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PEN_COUNT; i++) begin
        pal_r[i] <= (i == 0) ? RGB_BLACK : RGB_WHITE;
      end
    end else if (pen_wr.we && ({1'b0, pen_wr.idx} < 9'(PEN_COUNT))) begin
      pal_r[pen_wr.idx[PW-1:0]] <= pen_wr.data;
    end
  end

  always_comb begin
    if ({1'b0, fg_pen} < 9'(PEN_COUNT)) begin
      fg_color = pal_r[fg_pen[PW-1:0]];
    end else begin
      fg_color = RGB_BLACK;
    end
  end

endmodule

FILE: rtl/raster_fill_scroll_blitter.sv
// ----------------------------------------------------------------------------
// raster_fill_scroll_blitter: rectangle fill and scroll over a frame store
// Set pen: result in the cycle after start. Read pixel: the store read
// and then the result are registered. Fill and scroll: one pixel per
// cycle through the single frame store write port, then the result.
// Rejected or empty commands: result in the cycle after start. After reset
// the store is swept to black, one pixel per cycle, with busy high.
// ----------------------------------------------------------------------------
module raster_fill_scroll_blitter #(
  parameter int MAX_WIDTH  = rfsb_pkg::MAX_WIDTH_D,
  parameter int MAX_HEIGHT = rfsb_pkg::MAX_HEIGHT_D,
  parameter int PEN_COUNT  = rfsb_pkg::PEN_COUNT_D
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [10:0]        cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic signed [15:0] in_left,
  input  logic signed [15:0] in_top,
  input  logic signed [15:0] in_right,
  input  logic signed [15:0] in_bottom,
  input  logic signed [15:0] in_shift_x,
  input  logic signed [15:0] in_shift_y,
  input  logic [7:0]         in_pen_index,
  input  logic [23:0]        in_pen_color,
  output logic               out_valid,
  output logic [23:0]        out_pixel_rgb,
  output logic [1:0]         out_status
);
  import rfsb_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int SW = 18;

  state_t      state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  logic [10:0] width_r;
  logic [9:0]  height_r;
  logic [7:0]  fg_pen_r;
  logic        comp_r;

  logic [XW-1:0] x_r, x_nxt, x0_r, x0_nxt, x1_r, x1_nxt;
  logic [YW-1:0] y_r, y_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic signed [15:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic        scroll_r, scroll_nxt, xdesc_r, xdesc_nxt, ydesc_r, ydesc_nxt;

  logic          p_valid_r, p_valid_nxt;
  logic [AW-1:0] p_addr_r, p_addr_nxt;
  wsel_t         p_sel_r, p_sel_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_pixel_r, out_pixel_nxt;
  logic [1:0]  out_status_r, out_status_nxt;

  pen_wr_t     pen_wr;
  logic [23:0] fg_color;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [23:0]   mem_wdata, mem_rdata, p_wdata;

  logic [16:0] w_u, h_u;
  logic signed [16:0] w_s, h_s;
  logic signed [16:0] left_e, top_e, right_e, bottom_e;
  logic signed [16:0] cx0, cx1, cy0, cy1;
  logic        clip_empty, read_bad;

  logic signed [SW-1:0] sx, sy;
  logic        src_hit, row_end, last;
  logic [XW-1:0] col_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 10'd512;
      fg_pen_r <= 8'd1;
      comp_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_WIDTH:      width_r  <= cfg_wdata;
        CFG_HEIGHT:     height_r <= cfg_wdata[9:0];
        CFG_FG_PEN:     fg_pen_r <= cfg_wdata[7:0];
        CFG_COMPLEMENT: comp_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == 11'd0) begin
      w_u = 17'd1;
    end else if ({6'd0, width_r} > 17'(MAX_WIDTH)) begin
      w_u = 17'(MAX_WIDTH);
    end else begin
      w_u = {6'd0, width_r};
    end
    if (height_r == 10'd0) begin
      h_u = 17'd1;
    end else if ({7'd0, height_r} > 17'(MAX_HEIGHT)) begin
      h_u = 17'(MAX_HEIGHT);
    end else begin
      h_u = {7'd0, height_r};
    end
  end

  assign w_s      = $signed(w_u);
  assign h_s      = $signed(h_u);
  assign left_e   = {in_left[15], in_left};
  assign top_e    = {in_top[15], in_top};
  assign right_e  = {in_right[15], in_right};
  assign bottom_e = {in_bottom[15], in_bottom};

  assign cx0 = (left_e < 17'sd0) ? 17'sd0 : left_e;
  assign cy0 = (top_e < 17'sd0) ? 17'sd0 : top_e;
  assign cx1 = (right_e >= w_s) ? w_s - 17'sd1 : right_e;
  assign cy1 = (bottom_e >= h_s) ? h_s - 17'sd1 : bottom_e;
  assign clip_empty = (cx0 > cx1) || (cy0 > cy1);
  assign read_bad   = (left_e < 17'sd0) || (top_e < 17'sd0) ||
                      (left_e >= w_s) || (top_e >= h_s);

  assign sx = $signed({{(SW-XW){1'b0}}, x_r}) - $signed({{2{dx_r[15]}}, dx_r});
  assign sy = $signed({{(SW-YW){1'b0}}, y_r}) - $signed({{2{dy_r[15]}}, dy_r});
  assign src_hit = (sx >= $signed({{(SW-XW){1'b0}}, x0_r})) &&
                   (sx <= $signed({{(SW-XW){1'b0}}, x1_r})) &&
                   (sy >= $signed({{(SW-YW){1'b0}}, y0_r})) &&
                   (sy <= $signed({{(SW-YW){1'b0}}, y1_r}));

  assign col_start = xdesc_r ? x1_r : x0_r;
  assign row_end   = (x_r == (xdesc_r ? x0_r : x1_r));
  assign last      = row_end && (y_r == (ydesc_r ? y0_r : y1_r));

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    x0_nxt         = x0_r;
    x1_nxt         = x1_r;
    y0_nxt         = y0_r;
    y1_nxt         = y1_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    scroll_nxt     = scroll_r;
    xdesc_nxt      = xdesc_r;
    ydesc_nxt      = ydesc_r;
    p_valid_nxt    = 1'b0;
    p_addr_nxt     = {y_r, x_r};
    p_sel_nxt      = WD_COLOR;
    out_valid_nxt  = 1'b0;
    out_pixel_nxt  = RGB_BLACK;
    out_status_nxt = ST_DONE;
    pen_wr.we      = 1'b0;
    pen_wr.idx     = in_pen_index;
    pen_wr.data    = in_pen_color;
    mem_raddr      = {in_top[YW-1:0], in_left[XW-1:0]};

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (cmd_t'(in_cmd))
            CMD_SET_PEN: begin
              pen_wr.we     = 1'b1;
              out_valid_nxt = 1'b1;
              if ({1'b0, in_pen_index} >= 9'(PEN_COUNT)) begin
                out_status_nxt = ST_RANGE;
              end
            end
            CMD_READ: begin
              if (read_bad) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_RANGE;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
              if (clip_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                x0_nxt     = cx0[XW-1:0];
                x1_nxt     = cx1[XW-1:0];
                y0_nxt     = cy0[YW-1:0];
                y1_nxt     = cy1[YW-1:0];
                dx_nxt     = in_shift_x;
                dy_nxt     = in_shift_y;
                scroll_nxt = (cmd_t'(in_cmd) == CMD_SCROLL);
                xdesc_nxt  = (cmd_t'(in_cmd) == CMD_SCROLL) && (in_shift_x > 16'sd0);
                ydesc_nxt  = (cmd_t'(in_cmd) == CMD_SCROLL) && (in_shift_y > 16'sd0);
                x_nxt      = xdesc_nxt ? cx1[XW-1:0] : cx0[XW-1:0];
                y_nxt      = ydesc_nxt ? cy1[YW-1:0] : cy0[YW-1:0];
                state_nxt  = S_RUN;
              end
            end
          endcase
        end
      end
      S_RUN: begin
        p_valid_nxt = 1'b1;
        if (scroll_r) begin
          mem_raddr = {sy[YW-1:0], sx[XW-1:0]};
          p_sel_nxt = src_hit ? WD_SOURCE : WD_COLOR;
        end else begin
          mem_raddr = {y_r, x_r};
          p_sel_nxt = comp_r ? WD_INVERT : WD_COLOR;
        end
        if (row_end) begin
          x_nxt = col_start;
          y_nxt = ydesc_r ? y_r - 1'b1 : y_r + 1'b1;
        end else begin
          x_nxt = xdesc_r ? x_r - 1'b1 : x_r + 1'b1;
        end
        if (last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_pixel_nxt = mem_rdata;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    case (p_sel_r)
      WD_SOURCE: p_wdata = mem_rdata;
      WD_INVERT: p_wdata = mem_rdata ^ RGB_WHITE;
      default:   p_wdata = fg_color;
    endcase
  end

  assign mem_we    = (state_r == S_CLEAR) || p_valid_r;
  assign mem_waddr = (state_r == S_CLEAR) ? clr_r : p_addr_r;
  assign mem_wdata = (state_r == S_CLEAR) ? RGB_BLACK : p_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    x0_r         <= x0_nxt;
    x1_r         <= x1_nxt;
    y0_r         <= y0_nxt;
    y1_r         <= y1_nxt;
    dx_r         <= dx_nxt;
    dy_r         <= dy_nxt;
    scroll_r     <= scroll_nxt;
    xdesc_r      <= xdesc_nxt;
    ydesc_r      <= ydesc_nxt;
    p_addr_r     <= p_addr_nxt;
    p_sel_r      <= p_sel_nxt;
    out_pixel_r  <= out_pixel_nxt;
    out_status_r <= out_status_nxt;
  end

  rfsb_palette #(
    .PEN_COUNT(PEN_COUNT)
  ) u_palette (
    .clk     (clk),
    .rst_n   (rst_n),
    .pen_wr  (pen_wr),
    .fg_pen  (fg_pen_r),
    .fg_color(fg_color)
  );

  rfsb_frame_mem #(
    .AW(AW)
  ) u_frame_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_pixel_rgb = out_pixel_r;
  assign out_status    = out_status_r;

endmodule

FILE: rtl/rfsb_checker.sv
// ----------------------------------------------------------------------------
// rfsb_checker: port-level checks of the blitter
// Watches request and result ports and flags illegal result patterns.
// ----------------------------------------------------------------------------
module rfsb_checker #(
  parameter int PEN_COUNT = rfsb_pkg::PEN_COUNT_D
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_cmd,
  input logic [7:0]  in_pen_index,
  input logic        out_valid,
  input logic [23:0] out_pixel_rgb,
  input logic [1:0]  out_status
);
  import rfsb_pkg::*;

  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_EMPTY ||
                   out_status == ST_RANGE))
    else $error("undefined status");

  a_fail_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_pixel_rgb == RGB_BLACK)
    else $error("pixel on failed request");

  a_pen_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == CMD_SET_PEN |=> out_valid)
    else $error("set pen without result");

  a_pen_range: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == CMD_SET_PEN && {1'b0, in_pen_index} >= 9'(PEN_COUNT)
    |=> out_status == ST_RANGE)
    else $error("bad pen accepted");

endmodule

bind raster_fill_scroll_blitter rfsb_checker #(.PEN_COUNT(PEN_COUNT)) u_rfsb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_cmd       (in_cmd),
  .in_pen_index (in_pen_index),
  .out_valid    (out_valid),
  .out_pixel_rgb(out_pixel_rgb),
  .out_status   (out_status)
);

FILE: tb/tb_raster_fill_scroll_blitter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_raster_fill_scroll_blitter: self-checking bench for the fill/scroll blitter
// A table of directed requests and register writes, then random phases with
// fresh raster, pen and complement settings. A behavioral copy of the frame
// store and palette predicts each pixel/status pair that a table row does
// not give itself; results are compared in order as they are strobed out.
// ----------------------------------------------------------------------------
module tb_raster_fill_scroll_blitter;
  import rfsb_pkg::*;

  localparam int FB_W      = MAX_WIDTH_D;
  localparam int FB_H      = MAX_HEIGHT_D;
  localparam int PENS      = PEN_COUNT_D;
  localparam int CYC_LIMIT = 3000000;

  typedef struct {
    logic [23:0] pixel;
    status_t     status;
  } blit_result_t;

  typedef struct {
    bit          is_reg;
    cfg_idx_t    reg_idx;
    int          reg_val;
    cmd_t        cmd;
    int          left, top, right, bottom, dx, dy, pen_idx;
    logic [23:0] pen_col;
    bit          typed;
    logic [23:0] exp_pixel;
    status_t     exp_status;
  } script_row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_addr;
  logic [10:0] cfg_wdata;
  logic start, busy;
  logic [1:0] in_cmd;
  logic signed [15:0] in_left, in_top, in_right, in_bottom, in_shift_x, in_shift_y;
  logic [7:0] in_pen_index;
  logic [23:0] in_pen_color;
  logic out_valid;
  logic [23:0] out_pixel_rgb;
  logic [1:0] out_status;

  bit [23:0] frame_mirror [FB_W*FB_H];
  bit [23:0] scroll_copy [FB_W*FB_H];
  logic [23:0] pen_table [PENS];
  int unsigned raster_w, raster_h, fg_pen, complement;

  blit_result_t owed_results[$];
  script_row_t script[$];
  int errors;
  int cycles;

  raster_fill_scroll_blitter u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_left(in_left), .in_top(in_top), .in_right(in_right),
    .in_bottom(in_bottom), .in_shift_x(in_shift_x), .in_shift_y(in_shift_y),
    .in_pen_index(in_pen_index), .in_pen_color(in_pen_color),
    .out_valid(out_valid), .out_pixel_rgb(out_pixel_rgb), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYC_LIMIT) begin
        $display("[raster_fill_scroll_blitter] ERROR");
        $finish;
      end
    end
  end

  function automatic int clip_w();
    if (raster_w == 0) return 1;
    if (raster_w > FB_W) return FB_W;
    return raster_w;
  endfunction

  function automatic int clip_h();
    if (raster_h == 0) return 1;
    if (raster_h > FB_H) return FB_H;
    return raster_h;
  endfunction

  function automatic logic [23:0] fg_color();
    if (fg_pen >= PENS) return RGB_BLACK;
    return pen_table[fg_pen];
  endfunction

  function automatic void clear_mirror();
    foreach (frame_mirror[i]) frame_mirror[i] = '0;
    foreach (pen_table[i]) pen_table[i] = (i == 0) ? RGB_BLACK : RGB_WHITE;
    raster_w = 1024;
    raster_h = 512;
    fg_pen = 1;
    complement = 0;
  endfunction

  function automatic blit_result_t blit(script_row_t r);
    blit_result_t res;
    int w, h, x0, y0, x1, y1, sx, sy;
    logic [23:0] c;
    w = clip_w();
    h = clip_h();
    res.pixel = '0;
    res.status = ST_DONE;
    c = fg_color();
    case (r.cmd)
      CMD_SET_PEN: begin
        if (r.pen_idx >= PENS) res.status = ST_RANGE;
        else pen_table[r.pen_idx] = r.pen_col;
      end
      CMD_READ: begin
        if (r.left < 0 || r.top < 0 || r.left >= w || r.top >= h) res.status = ST_RANGE;
        else res.pixel = frame_mirror[r.top*FB_W + r.left];
      end
      default: begin
        x0 = (r.left < 0) ? 0 : r.left;
        y0 = (r.top < 0) ? 0 : r.top;
        x1 = (r.right >= w) ? w - 1 : r.right;
        y1 = (r.bottom >= h) ? h - 1 : r.bottom;
        if (x0 > x1 || y0 > y1) begin
          res.status = ST_EMPTY;
        end else if (r.cmd == CMD_FILL) begin
          for (int y = y0; y <= y1; y++)
            for (int x = x0; x <= x1; x++)
              frame_mirror[y*FB_W+x] = complement ? frame_mirror[y*FB_W+x] ^ RGB_WHITE : c;
        end else begin
          for (int y = y0; y <= y1; y++)
            for (int x = x0; x <= x1; x++)
              scroll_copy[y*FB_W+x] = frame_mirror[y*FB_W+x];
          for (int y = y0; y <= y1; y++)
            for (int x = x0; x <= x1; x++) begin
              sx = x - r.dx;
              sy = y - r.dy;
              if (sx >= x0 && sx <= x1 && sy >= y0 && sy <= y1)
                frame_mirror[y*FB_W+x] = scroll_copy[sy*FB_W+sx];
              else
                frame_mirror[y*FB_W+x] = c;
            end
        end
      end
    endcase
    return res;
  endfunction

  function automatic script_row_t blank_row();
    script_row_t s;
    s.is_reg = 0; s.reg_idx = CFG_WIDTH; s.reg_val = 0;
    s.cmd = CMD_FILL; s.left = 0; s.top = 0; s.right = 0; s.bottom = 0;
    s.dx = 0; s.dy = 0; s.pen_idx = 0; s.pen_col = '0;
    s.typed = 0; s.exp_pixel = '0; s.exp_status = ST_DONE;
    return s;
  endfunction

  function automatic void add_req(cmd_t c, int l, int t, int r, int b, int dx = 0, int dy = 0,
                                  int pi = 0, logic [23:0] pc = '0, bit typed = 0,
                                  logic [23:0] ep = '0, status_t es = ST_DONE);
    script_row_t s;
    s.is_reg = 0; s.reg_idx = CFG_WIDTH; s.reg_val = 0;
    s.cmd = c; s.left = l; s.top = t; s.right = r; s.bottom = b;
    s.dx = dx; s.dy = dy; s.pen_idx = pi; s.pen_col = pc;
    s.typed = typed; s.exp_pixel = ep; s.exp_status = es;
    script.push_back(s);
  endfunction

  function automatic void add_reg(cfg_idx_t idx, int val);
    script_row_t s;
    s = blank_row();
    s.is_reg = 1; s.reg_idx = idx; s.reg_val = val;
    script.push_back(s);
  endfunction

  task automatic write_reg(cfg_idx_t idx, int val);
    @(negedge clk);
    start = 1'b0;
    while (owed_results.size() != 0 || busy !== 1'b0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val[10:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_WIDTH:  raster_w = val & 'h7ff;
      CFG_HEIGHT: raster_h = val & 'h3ff;
      CFG_FG_PEN: fg_pen = val & 'hff;
      default:    complement = val & 1;
    endcase
  endtask

  task automatic send_req(script_row_t s, bit allow_idle);
    blit_result_t res;
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd = s.cmd;
    in_left = s.left[15:0];
    in_top = s.top[15:0];
    in_right = s.right[15:0];
    in_bottom = s.bottom[15:0];
    in_shift_x = s.dx[15:0];
    in_shift_y = s.dy[15:0];
    in_pen_index = s.pen_idx[7:0];
    in_pen_color = s.pen_col;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    res = blit(s);
    if (s.typed) begin
      res.pixel = s.exp_pixel;
      res.status = s.exp_status;
    end
    owed_results.push_back(res);
    @(negedge clk);
    start = 1'b0;
  endtask

  always @(posedge clk) begin
    blit_result_t e;
    if (rst_n && out_valid === 1'b1) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result pixel_rgb=%h status=%0d", out_pixel_rgb, out_status);
        errors++;
      end else begin
        e = owed_results.pop_front();
        if (out_pixel_rgb !== e.pixel) begin
          $error("pixel_rgb expected %h actual %h", e.pixel, out_pixel_rgb);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status);
          errors++;
        end
      end
    end
  end

  function automatic int coord(bit wide);
    if (wide && $urandom_range(0, 4) == 0) return $signed(16'($urandom_range(0, 65535)));
    return $urandom_range(0, 50) - 6;
  endfunction

  initial begin
    script_row_t s;
    bit wide;
    int kind;
    errors = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    start = 1'b0;
    in_cmd = '0; in_left = '0; in_top = '0; in_right = '0; in_bottom = '0;
    in_shift_x = '0; in_shift_y = '0; in_pen_index = '0; in_pen_color = '0;
    clear_mirror();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    add_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, RGB_BLACK, ST_DONE);
    add_req(CMD_READ, 1023, 511, 0, 0, 0, 0, 0, 0, 1, RGB_BLACK, ST_DONE);
    add_req(CMD_READ, -1, 0, 0, 0, 0, 0, 0, 0, 1, RGB_BLACK, ST_RANGE);
    add_req(CMD_READ, 1024, 0, 0, 0, 0, 0, 0, 0, 1, RGB_BLACK, ST_RANGE);
    add_req(CMD_READ, 0, 512, 0, 0, 0, 0, 0, 0, 1, RGB_BLACK, ST_RANGE);
    add_req(CMD_SET_PEN, 0, 0, 0, 0, 0, 0, 255, 24'hFFFFFF, 1, RGB_BLACK, ST_RANGE);
    add_req(CMD_SET_PEN, 0, 0, 0, 0, 0, 0, 16, 24'h123456, 1, RGB_BLACK, ST_RANGE);
    add_req(CMD_SET_PEN, 0, 0, 0, 0, 0, 0, 3, 24'h123456, 1, RGB_BLACK, ST_DONE);
    add_req(CMD_FILL, -32768, -32768, 7, 3);
    add_req(CMD_READ, 7, 3, 0, 0, 0, 0, 0, 0, 1, RGB_WHITE, ST_DONE);
    add_req(CMD_FILL, 10, 0, 5, 3, 0, 0, 0, 0, 1, RGB_BLACK, ST_EMPTY);
    add_req(CMD_FILL, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 1, RGB_BLACK, ST_EMPTY);
    add_req(CMD_SCROLL, 0, 0, -32768, -32768, 0, 0, 0, 0, 1, RGB_BLACK, ST_EMPTY);
    add_reg(CFG_FG_PEN, 3);
    add_req(CMD_FILL, 2, 1, 4, 2);
    add_req(CMD_SCROLL, 0, 0, 9, 4, 2, 1);
    add_req(CMD_SCROLL, 0, 0, 9, 4, -32768, 32767);
    add_reg(CFG_COMPLEMENT, 1);
    add_req(CMD_FILL, 1, 1, 5, 3);
    add_req(CMD_SCROLL, 0, 0, 9, 4, -1, -1);
    add_req(CMD_READ, 2, 1, 0, 0);
    add_reg(CFG_WIDTH, 16);
    add_reg(CFG_HEIGHT, 8);
    add_reg(CFG_FG_PEN, 255);
    add_req(CMD_SCROLL, -32768, -32768, 32767, 32767, 3, -2);
    add_req(CMD_READ, 20, 0, 0, 0, 0, 0, 0, 0, 1, RGB_BLACK, ST_RANGE);
    add_reg(CFG_COMPLEMENT, 0);
    add_reg(CFG_WIDTH, 0);
    add_reg(CFG_HEIGHT, 0);
    add_reg(CFG_FG_PEN, 0);
    add_req(CMD_FILL, -32768, -32768, 32767, 32767);
    add_req(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0, 1, RGB_BLACK, ST_RANGE);
    add_reg(CFG_WIDTH, 2047);
    add_reg(CFG_HEIGHT, 1023);
    add_req(CMD_READ, 1023, 511, 0, 0, 0, 0, 0, 0, 1, RGB_BLACK, ST_DONE);
    add_req(CMD_READ, 5, 3, 0, 0);

    foreach (script[i]) begin
      if (script[i].is_reg) write_reg(script[i].reg_idx, script[i].reg_val);
      else send_req(script[i], 1);
    end

    for (int ph = 0; ph < 10; ph++) begin
      kind = $urandom_range(0, 9);
      write_reg(CFG_WIDTH, kind == 0 ? 0 : kind == 1 ? 2047 : kind == 2 ? 1024
                           : $urandom_range(1, 40));
      kind = $urandom_range(0, 9);
      write_reg(CFG_HEIGHT, kind == 0 ? 0 : kind == 1 ? 1023 : kind == 2 ? 512
                            : $urandom_range(1, 24));
      write_reg(CFG_FG_PEN, $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 15));
      write_reg(CFG_COMPLEMENT, $urandom_range(0, 1));
      wide = (clip_w() <= 64 && clip_h() <= 64);
      for (int k = 0; k < 10; k++) begin
        s = blank_row();
        kind = $urandom_range(0, 99);
        s.cmd = kind < 30 ? CMD_FILL : kind < 60 ? CMD_SCROLL : kind < 75 ? CMD_SET_PEN
                : CMD_READ;
        s.left = coord(wide);
        s.top = coord(wide);
        if ($urandom_range(0, 9) < 7) begin
          s.right = s.left + $urandom_range(0, 12);
          s.bottom = s.top + $urandom_range(0, 12);
          if (!wide) begin
            if (s.right > 60) s.right = 60;
            if (s.bottom > 60) s.bottom = 60;
          end
        end else begin
          s.right = coord(wide);
          s.bottom = coord(wide);
        end
        if ($urandom_range(0, 3) == 0) begin
          s.dx = $signed(16'($urandom_range(0, 65535)));
          s.dy = $signed(16'($urandom_range(0, 65535)));
        end else begin
          s.dx = $urandom_range(0, 10) - 5;
          s.dy = $urandom_range(0, 10) - 5;
        end
        s.pen_idx = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 15);
        s.pen_col = 24'($urandom_range(0, 24'hFFFFFF));
        send_req(s, ph < 7);
      end
    end
    start = 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[raster_fill_scroll_blitter] OK");
    end else begin
      $display("[raster_fill_scroll_blitter] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rfsb_pkg.sv
rtl/rfsb_frame_mem.sv
rtl/rfsb_palette.sv
rtl/raster_fill_scroll_blitter.sv
rtl/rfsb_checker.sv
tb/tb_raster_fill_scroll_blitter.sv
